// File: src/oets_pkg.sv
`timescale 1ns / 1ps

package oets_pkg;

  localparam int MAX_KEYS = 64;
  localparam int KEY_W    = 32;
  // count must hold MAX_KEYS itself
  localparam int CNT_W    = $clog2(MAX_KEYS + 1);

  // controller to datapath
  typedef struct packed {
    logic load;   // shift a new key in at the top
    logic phase;  // run one compare-exchange phase
    logic odd;    // phase over pairs starting at odd positions
    logic emit;   // capture the top cell and shift the row up
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic swapped;  // some pair swapped in this phase
  } stat_t;

endpackage

// File: src/oets_dp.sv
`timescale 1ns / 1ps

module oets_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  oets_pkg::cmd_t                      cmd,
  input  logic signed [oets_pkg::KEY_W-1:0]   key,
  output oets_pkg::stat_t                     stat,
  output logic signed [oets_pkg::KEY_W-1:0]   sorted_key
);

  // row of cells, kept in descending order so the smallest sits at the top
  logic signed [oets_pkg::KEY_W-1:0] cells [oets_pkg::MAX_KEYS];
  logic signed [oets_pkg::KEY_W-1:0] from_above [oets_pkg::MAX_KEYS];
  logic signed [oets_pkg::KEY_W-1:0] from_below [oets_pkg::MAX_KEYS];
  logic [oets_pkg::MAX_KEYS-1:0]     valid;
  logic [oets_pkg::MAX_KEYS-2:0]     swap_pair;
  logic [oets_pkg::MAX_KEYS-1:0]     take_above;
  logic [oets_pkg::MAX_KEYS-1:0]     take_below;

  // one comparator per adjacent pair, enabled by phase parity
  for (genvar i = 0; i < oets_pkg::MAX_KEYS - 1; i++) begin : g_pair
    localparam logic ODD_PAIR = ((i % 2) == 1);
    assign swap_pair[i] = cmd.phase && (cmd.odd == ODD_PAIR) && valid[i] && valid[i+1]
                          && (cells[i] < cells[i+1]);
  end

  for (genvar g = 0; g < oets_pkg::MAX_KEYS; g++) begin : g_cell
    if (g == oets_pkg::MAX_KEYS - 1) begin : g_top
      assign from_above[g] = key;
      assign take_above[g] = 1'b0;
    end else begin : g_mid_hi
      assign from_above[g] = cells[g+1];
      assign take_above[g] = swap_pair[g];
    end
    if (g == 0) begin : g_bot
      assign from_below[g] = cells[g];
      assign take_below[g] = 1'b0;
    end else begin : g_mid_lo
      assign from_below[g] = cells[g-1];
      assign take_below[g] = swap_pair[g-1];
    end

    always_ff @(posedge clk) begin
      if (cmd.load) begin
        cells[g] <= from_above[g];
      end else if (cmd.emit) begin
        cells[g] <= from_below[g];
      end else if (take_above[g]) begin
        cells[g] <= from_above[g];
      end else if (take_below[g]) begin
        cells[g] <= from_below[g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (cmd.load) begin
      valid <= {1'b1, valid[oets_pkg::MAX_KEYS-1:1]};
    end else if (cmd.emit) begin
      valid <= {valid[oets_pkg::MAX_KEYS-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      sorted_key <= cells[oets_pkg::MAX_KEYS-1];
    end
  end

  assign stat.swapped = |swap_pair;

endmodule

// File: src/oets_ctrl.sv
`timescale 1ns / 1ps

module oets_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             last,
  input  oets_pkg::stat_t  stat,
  output oets_pkg::cmd_t   cmd,
  output logic             busy,
  output logic             strobe,
  output logic             final_res
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ODD,
    ST_EVEN,
    ST_EMIT
  } state_t;

  state_t                     state;
  logic [oets_pkg::CNT_W-1:0] count;
  logic                       pass_swapped;
  logic                       full;

  assign full = (count == oets_pkg::CNT_W'(oets_pkg::MAX_KEYS));

  always_comb begin
    cmd.load  = (state == ST_IDLE) && start && !full;
    cmd.phase = (state == ST_ODD) || (state == ST_EVEN);
    cmd.odd   = (state == ST_ODD);
    cmd.emit  = (state == ST_EMIT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      count        <= '0;
      pass_swapped <= 1'b0;
      busy         <= 1'b0;
      strobe       <= 1'b0;
      final_res    <= 1'b0;
    end else begin
      strobe    <= 1'b0;
      final_res <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            if (!full) begin
              count <= count + 1'b1;
            end
            if (last) begin
              state <= ST_ODD;
              busy  <= 1'b1;
            end
          end
        end
        ST_ODD: begin
          pass_swapped <= stat.swapped;
          state        <= ST_EVEN;
        end
        ST_EVEN: begin
          if (pass_swapped || stat.swapped) begin
            state <= ST_ODD;
          end else begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          strobe    <= 1'b1;
          final_res <= (count == oets_pkg::CNT_W'(1));
          count     <= count - 1'b1;
          if (count == oets_pkg::CNT_W'(1)) begin
            state <= ST_IDLE;
            busy  <= 1'b0;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: src/odd_even_transposition_sorter_top.sv
`timescale 1ns / 1ps

// channel   | handshake            | payload
// ----------+----------------------+--------------------------
// request   | start, busy (out)    | key[31:0] signed, last
// result    | strobe (out)         | sorted_key[31:0] signed, final_res
//
// a key is taken with each start while busy is low; keys past 64 are dropped, last still closes the list
// sorting runs alternating odd/even phases over a row of 64 compare cells,
// repeated until a full pass swaps nothing
// results then leave one per cycle, one per stored key, smallest first, no gaps
// busy is high from the request with last until the final result is shown
// rst is synchronous; results cannot be held off by the receiver

module odd_even_transposition_sorter_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [oets_pkg::KEY_W-1:0]  key,
  input  logic                               last,
  output logic                               strobe,
  output logic signed [oets_pkg::KEY_W-1:0]  sorted_key,
  output logic                               final_res
);

  // command and status between controller and cell row
  oets_pkg::cmd_t  cmd;
  oets_pkg::stat_t stat;

  // sequencer: load, phase stepping, swap tracking, emit count
  oets_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .last      (last),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .strobe    (strobe),
    .final_res (final_res)
  );

  // row of key cells with one comparator per adjacent pair
  oets_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .key        (key),
    .stat       (stat),
    .sorted_key (sorted_key)
  );

endmodule

// File: src/oets_checker.sv
`timescale 1ns / 1ps

module oets_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic last,
  input logic strobe,
  input logic final_res
);

  // a closing request always starts the sort
  a_last_sets_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && last |=> busy)
    else $error("busy not raised after closing request");

  // results come only out of a busy period
  a_strobe_after_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy))
    else $error("result outside a sort");

  // results of one list leave back to back
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    strobe && !final_res |=> strobe)
    else $error("gap inside result burst");

  // the final result ends the burst and releases busy
  a_final_ends: assert property (@(posedge clk) disable iff (rst)
    strobe && final_res |-> !busy ##1 !strobe)
    else $error("burst did not end on final result");

endmodule

bind odd_even_transposition_sorter_top oets_checker u_oets_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .last      (last),
  .strobe    (strobe),
  .final_res (final_res)
);

// File: verif/odd_even_transposition_sorter_top_tb.sv
`timescale 1ns / 1ps

module odd_even_transposition_sorter_top_tb;

  localparam int CLK_HALF   = 4;
  localparam int RST_CYCLES = 9;
  // longest quiet stretch: a full 64-key sort, a long sender gap and generous margin
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 16;
  localparam int RANDOM_ITEMS   = 355;

  localparam logic signed [oets_pkg::KEY_W-1:0] KEY_MIN = {1'b1, {(oets_pkg::KEY_W-1){1'b0}}};
  localparam logic signed [oets_pkg::KEY_W-1:0] KEY_MAX = {1'b0, {(oets_pkg::KEY_W-1){1'b1}}};

  // one sorted key as it should leave the block
  typedef struct {
    logic signed [oets_pkg::KEY_W-1:0] sorted_key;
    logic                              final_res;
  } sorted_result_t;

  // keeps its own copy of the list being collected, sorts it the way the
  // block does once the list closes, and holds the results still to come
  class sorter_scoreboard;
    logic signed [oets_pkg::KEY_W-1:0] held_keys [oets_pkg::MAX_KEYS];
    int unsigned                       held_count;
    sorted_result_t                    pending_results [$];
    int unsigned                       mismatches;

    function new();
      held_count  = 0;
      mismatches  = 0;
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      $display("%0t ns mismatch: %s", $realtime, msg);
    endtask

    // odd phase over (1,2),(3,4).. then even phase over (0,1),(2,3)..
    // until a whole pass leaves the list alone
    function void sort_held(int unsigned n);
      logic                              any_swap;
      logic signed [oets_pkg::KEY_W-1:0] tmp;
      do begin
        any_swap = 1'b0;
        for (int i = 1; i + 1 < n; i += 2) begin
          if (held_keys[i] > held_keys[i+1]) begin
            tmp = held_keys[i];
            held_keys[i] = held_keys[i+1];
            held_keys[i+1] = tmp;
            any_swap = 1'b1;
          end
        end
        for (int i = 0; i + 1 < n; i += 2) begin
          if (held_keys[i] > held_keys[i+1]) begin
            tmp = held_keys[i];
            held_keys[i] = held_keys[i+1];
            held_keys[i+1] = tmp;
            any_swap = 1'b1;
          end
        end
      end while (any_swap);
    endfunction

    function void note_request(logic signed [oets_pkg::KEY_W-1:0] k, logic l);
      sorted_result_t r;
      // keys past a full store are dropped, last still closes the list
      if (held_count < oets_pkg::MAX_KEYS) begin
        held_keys[held_count] = k;
        held_count++;
      end
      if (l) begin
        sort_held(held_count);
        for (int i = 0; i < held_count; i++) begin
          r.sorted_key = held_keys[i];
          r.final_res  = (i + 1 == held_count);
          pending_results = {pending_results, r};
        end
        held_count = 0;
      end
    endfunction

    task check_result(logic signed [oets_pkg::KEY_W-1:0] k, logic f);
      sorted_result_t r;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result key %0d final_res %0b", k, f));
      end else begin
        r = pending_results.pop_front();
        if (k !== r.sorted_key)
          report_mismatch($sformatf("sorted_key %0d, want %0d", k, r.sorted_key));
        if (f !== r.final_res)
          report_mismatch($sformatf("final_res %0b, want %0b", f, r.final_res));
      end
    endtask

    function int unsigned pending();
      return pending_results.size();
    endfunction

    task check_drained();
      if (pending_results.size() != 0)
        report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    endtask
  endclass

  logic                              clk   = 1'b0;
  logic                              rst   = 1'b1;
  logic                              start = 1'b0;
  logic signed [oets_pkg::KEY_W-1:0] key   = '0;
  logic                              last  = 1'b0;
  logic                              busy;
  logic                              strobe;
  logic signed [oets_pkg::KEY_W-1:0] sorted_key;
  logic                              final_res;

  sorter_scoreboard sb = new();
  int unsigned      quiet_cycles = 0;
  int unsigned      items_sent   = 0;
  logic             burst_mode   = 1'b0;

  always #(CLK_HALF) clk = ~clk;

  odd_even_transposition_sorter_top u_top (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .key        (key),
    .last       (last),
    .strobe     (strobe),
    .sorted_key (sorted_key),
    .final_res  (final_res)
  );

  // result side: every strobe cycle carries one sorted key, nothing can stall it;
  // the watchdog counts edges where neither side moves anything
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles = 0;
    end else begin
      if (strobe)
        sb.check_result(sorted_key, final_res);
      if (strobe || (start && !busy))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // mostly back-to-back or short gaps, now and then a long pause;
  // burst mode gives stretches with no idling at all
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 55)
      return 0;
    else if (r < 90)
      return $urandom_range(1, 3);
    else
      return $urandom_range(8, 40);
  endfunction

  // spread of key values: extremes, a narrow band so equal keys show up
  // often, and full-width random patterns
  function automatic logic signed [oets_pkg::KEY_W-1:0] pick_key();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      case ($urandom_range(0, 4))
        0:       return KEY_MIN;
        1:       return KEY_MAX;
        2:       return '0;
        3:       return -1;
        default: return 1;
      endcase
    end else if (r <= 3) begin
      return int'($urandom_range(0, 16)) - 8;
    end else begin
      return $urandom;
    end
  endfunction

  // present one request, hold it until the block takes it, then optionally
  // drop start for a while; start stays up when the next request follows
  task automatic send_key(logic signed [oets_pkg::KEY_W-1:0] k, logic l);
    int unsigned gap;
    start <= 1'b1;
    key   <= k;
    last  <= l;
    do @(posedge clk); while (busy);
    sb.note_request(k, l);
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      key   <= $urandom;
      last  <= 1'($urandom_range(0, 1));
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_list(int unsigned len);
    for (int i = 0; i < len; i++)
      send_key(pick_key(), i == len - 1);
  endtask

  initial begin
    int unsigned list_no;
    int unsigned len;

    repeat (RST_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // single-key lists come back unchanged with final_res set
    send_key(KEY_MAX, 1'b1);
    send_key(KEY_MIN, 1'b1);
    // extremes mixed with duplicates
    send_key(KEY_MAX, 1'b0);
    send_key(KEY_MIN, 1'b0);
    send_key('0, 1'b0);
    send_key(-1, 1'b0);
    send_key(1, 1'b0);
    send_key(KEY_MIN, 1'b0);
    send_key(KEY_MAX, 1'b1);
    // strictly descending: worst case for swaps
    for (int i = 5; i >= 0; i--)
      send_key(i, i == 0);
    // all equal keys never swap
    for (int i = 0; i < 4; i++)
      send_key(7, i == 3);
    // already in order
    send_key(-5, 1'b0);
    send_key(5, 1'b1);

    // random lists, mostly short; a few fill the store exactly or overrun it
    // so keys get dropped and last arrives on a dropped key
    list_no = 0;
    while (items_sent < RANDOM_ITEMS) begin
      burst_mode = ($urandom_range(0, 9) < 3);
      case (list_no)
        2:       len = 66;
        5:       len = oets_pkg::MAX_KEYS;
        8:       len = oets_pkg::MAX_KEYS + 1;
        default: len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 10)
                                                  : $urandom_range(11, 30);
      endcase
      send_list(len);
      list_no++;
    end
    burst_mode = 1'b0;

    start <= 1'b0;
    while (sb.pending() != 0)
      @(posedge clk);
    // no stray results may follow the final one
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.check_drained();

    if (sb.mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
